[src/ssle_pkg.sv]
`default_nettype none

package ssle_pkg;

  // Pool geometry and field widths.
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int LINK_W      = $clog2(CAPACITY + 1);
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 3;
  localparam int STEP_W      = 4;

  // A link equal to the pool size marks the end of the list.
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_DELETED = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NOSTART,
    C_PNIL,
    C_MORE,
    C_DUP,
    C_FULL,
    C_MISS,
    C_DEL
  } cond_t;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_ISSUE,
    A_WALK,
    A_POP,
    A_NODE,
    A_LINK,
    A_UNLINK,
    A_DUP,
    A_FULL,
    A_MISS
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    act_t  act;
  } ctrl_t;

  // Datapath flags tested by the jump conditions.
  typedef struct packed {
    logic start;
    logic p_nil;
    logic more;
    logic dup;
    logic full;
    logic miss;
    logic del;
  } flags_t;

  // Program step addresses.
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_HEAD     = 4'd1;
  localparam step_t S_WALK     = 4'd2;
  localparam step_t S_DEC_DUP  = 4'd3;
  localparam step_t S_DEC_FULL = 4'd4;
  localparam step_t S_DEC_MISS = 4'd5;
  localparam step_t S_DEC_DEL  = 4'd6;
  localparam step_t S_POP      = 4'd7;
  localparam step_t S_NODE     = 4'd8;
  localparam step_t S_LINK     = 4'd9;
  localparam step_t S_REP_DUP  = 4'd10;
  localparam step_t S_REP_FULL = 4'd11;
  localparam step_t S_REP_MISS = 4'd12;
  localparam step_t S_UNLINK   = 4'd13;

  // Control store: when the condition holds the step jumps to target,
  // otherwise it falls through to the next step.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      S_IDLE:     w = '{C_NOSTART, S_IDLE,     A_LOAD};
      S_HEAD:     w = '{C_PNIL,    S_DEC_DUP,  A_ISSUE};
      S_WALK:     w = '{C_MORE,    S_WALK,     A_WALK};
      S_DEC_DUP:  w = '{C_DUP,     S_REP_DUP,  A_NONE};
      S_DEC_FULL: w = '{C_FULL,    S_REP_FULL, A_NONE};
      S_DEC_MISS: w = '{C_MISS,    S_REP_MISS, A_NONE};
      S_DEC_DEL:  w = '{C_DEL,     S_UNLINK,   A_NONE};
      S_POP:      w = '{C_ALWAYS,  S_NODE,     A_POP};
      S_NODE:     w = '{C_ALWAYS,  S_LINK,     A_NODE};
      S_LINK:     w = '{C_ALWAYS,  S_IDLE,     A_LINK};
      S_REP_DUP:  w = '{C_ALWAYS,  S_IDLE,     A_DUP};
      S_REP_FULL: w = '{C_ALWAYS,  S_IDLE,     A_FULL};
      S_REP_MISS: w = '{C_ALWAYS,  S_IDLE,     A_MISS};
      S_UNLINK:   w = '{C_ALWAYS,  S_IDLE,     A_UNLINK};
      default:    w = '{C_ALWAYS,  S_IDLE,     A_NONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[src/ssle_ram.sv]
`default_nettype none

module ssle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/ssle_seq.sv]
`default_nettype none

module ssle_seq import ssle_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output ctrl_t       ctrl,
  output logic        busy
);

  step_t step_r;
  step_t step_nxt;
  logic  take;

  // Current control word comes straight from the control store.
  assign ctrl = ucode(step_r);
  assign busy = (step_r != S_IDLE);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:  take = 1'b1;
      C_NOSTART: take = !flags.start;
      C_PNIL:    take = flags.p_nil;
      C_MORE:    take = flags.more;
      C_DUP:     take = flags.dup;
      C_FULL:    take = flags.full;
      C_MISS:    take = flags.miss;
      C_DEL:     take = flags.del;
      default:   take = 1'b0;
    endcase
    step_nxt = take ? ctrl.target : step_r + step_t'(1);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

[src/sorted_set_list_engine_core.sv]
`default_nettype none

// A transaction walks the list from the head and visits up to 64 nodes, one node per cycle,
// then ends in a duplicate, a full pool, a miss or a delete, tested in that order, or else
// in an insert. busy falls in the cycle the result is shown, so the next transaction can
// start at once. Reset (synchronous, active low) empties the list and frees every node.
// The result strobe cannot be held off by the receiver.
module sorted_set_list_engine_core import ssle_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                               out_valid,
  output logic             [STATUS_W-1:0]    out_status,
  output logic             [COUNT_W-1:0]     out_entry_count
);

  ctrl_t  ctrl;
  flags_t flags;

  // Transaction registers.
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                          op_r, op_nxt;
  logic                          found_r, found_nxt;
  logic [LINK_W-1:0]             p_r, p_nxt;
  logic [LINK_W-1:0]             before_r, before_nxt;
  logic [IDX_W-1:0]              hit_r, hit_nxt;
  logic [IDX_W-1:0]              new_r, new_nxt;

  // List and pool state.
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [LINK_W-1:0]   free_top_r, free_top_nxt;
  logic [CAPACITY-1:0] fs_vld_r, fs_vld_nxt;
  logic                fs_hit_vld_r;
  logic [IDX_W-1:0]    fs_raddr_r;

  // Result registers.
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  // Memory ports.
  logic [IDX_W-1:0]       node_raddr;
  logic                   val_we, next_we, prev_we, fs_we;
  logic [IDX_W-1:0]       val_waddr, next_waddr, prev_waddr, fs_waddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;
  logic [LINK_W-1:0]      next_wdata, next_rdata, prev_wdata, prev_rdata;
  logic [IDX_W-1:0]       fs_wdata, fs_rdata, fs_pop_addr, pop_idx;

  logic val_lt, val_eq;

  ssle_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  ssle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(node_raddr), .rdata(val_rdata)
  );

  ssle_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(node_raddr), .rdata(next_rdata)
  );

  ssle_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(node_raddr), .rdata(prev_rdata)
  );

  ssle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_pop_addr), .rdata(fs_rdata)
  );

  // Compare the node just read against the key.
  assign val_lt = ($signed(val_rdata) < key_r);
  assign val_eq = ($signed(val_rdata) == key_r);

  // The walk chains reads: the next link read out addresses the following node.
  assign node_raddr = (ctrl.act == A_WALK) ? next_rdata[IDX_W-1:0] : p_r[IDX_W-1:0];

  // The free stack is read at its top all the time; a slot never written holds its index.
  assign fs_pop_addr = IDX_W'(free_top_r - LINK_W'(1));
  assign pop_idx     = fs_hit_vld_r ? fs_rdata : fs_raddr_r;

  // Flags for the sequencer. Only an insert can be refused for an exhausted pool.
  always_comb begin
    flags.start = start;
    flags.p_nil = (p_r == NIL_LINK);
    flags.more  = val_lt && (next_rdata != NIL_LINK);
    flags.dup   = !op_r && found_r;
    flags.full  = !op_r && (free_top_r == '0);
    flags.miss  = op_r && !found_r;
    flags.del   = op_r;
  end

  // Datapath driven by the current control word.
  always_comb begin
    key_nxt        = key_r;
    op_nxt         = op_r;
    found_nxt      = found_r;
    p_nxt          = p_r;
    before_nxt     = before_r;
    hit_nxt        = hit_r;
    new_nxt        = new_r;
    head_nxt       = head_r;
    free_top_nxt   = free_top_r;
    fs_vld_nxt     = fs_vld_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    val_we         = 1'b0;
    val_waddr      = pop_idx;
    val_wdata      = key_r;
    next_we        = 1'b0;
    next_waddr     = pop_idx;
    next_wdata     = p_r;
    prev_we        = 1'b0;
    prev_waddr     = pop_idx;
    prev_wdata     = before_r;
    fs_we          = 1'b0;
    fs_waddr       = free_top_r[IDX_W-1:0];
    fs_wdata       = hit_r;

    case (ctrl.act)
      A_LOAD: begin
        if (start) begin
          key_nxt    = in_value;
          op_nxt     = in_op;
          found_nxt  = 1'b0;
          p_nxt      = head_r;
          before_nxt = NIL_LINK;
        end
      end
      A_WALK: begin
        // On a match, p takes the successor and before the predecessor.
        if (val_eq) begin
          found_nxt  = 1'b1;
          hit_nxt    = p_r[IDX_W-1:0];
          p_nxt      = next_rdata;
          before_nxt = prev_rdata;
        end else if (val_lt) begin
          before_nxt = p_r;
          p_nxt      = next_rdata;
        end
      end
      A_POP: begin
        free_top_nxt = free_top_r - LINK_W'(1);
      end
      A_NODE: begin
        // Fill the new node between before and its successor.
        new_nxt = pop_idx;
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      A_LINK: begin
        if (before_r != NIL_LINK) begin
          next_we    = 1'b1;
          next_waddr = before_r[IDX_W-1:0];
          next_wdata = LINK_W'(new_r);
        end else begin
          head_nxt = LINK_W'(new_r);
        end
        if (p_r != NIL_LINK) begin
          prev_we    = 1'b1;
          prev_waddr = p_r[IDX_W-1:0];
          prev_wdata = LINK_W'(new_r);
        end
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_ADDED;
      end
      A_UNLINK: begin
        // Bridge the neighbors of the hit node and return it to the pool.
        if (before_r != NIL_LINK) begin
          next_we    = 1'b1;
          next_waddr = before_r[IDX_W-1:0];
          next_wdata = p_r;
        end else begin
          head_nxt = p_r;
        end
        if (p_r != NIL_LINK) begin
          prev_we    = 1'b1;
          prev_waddr = p_r[IDX_W-1:0];
          prev_wdata = before_r;
        end
        fs_we                                 = 1'b1;
        fs_vld_nxt[free_top_r[IDX_W-1:0]]     = 1'b1;
        free_top_nxt                          = free_top_r + LINK_W'(1);
        out_valid_nxt                         = 1'b1;
        out_status_nxt                        = ST_DELETED;
      end
      A_DUP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DUP;
      end
      A_FULL: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_FULL;
      end
      A_MISS: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_MISSING;
      end
      default: begin
      end
    endcase

    // Entries held equal nodes not on the free stack.
    out_count_nxt = COUNT_W'(NIL_LINK - free_top_nxt);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL_LINK;
      free_top_r  <= LINK_W'(CAPACITY);
      fs_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      free_top_r  <= free_top_nxt;
      fs_vld_r    <= fs_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    op_r         <= op_nxt;
    found_r      <= found_nxt;
    p_r          <= p_nxt;
    before_r     <= before_nxt;
    hit_r        <= hit_nxt;
    new_r        <= new_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    fs_raddr_r   <= fs_pop_addr;
    fs_hit_vld_r <= fs_vld_r[fs_pop_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

[tb/sorted_set_list_engine_core_tb.sv]
`timescale 1ns / 100ps

module sorted_set_list_engine_core_tb;
  import ssle_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 80;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } list_op_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   entry_count;
  } list_result_t;

  typedef struct {
    list_op_t                      op;
    logic signed [VALUE_WIDTH-1:0] value;
    bit                            typed;
    status_t                       status;
    logic [COUNT_W-1:0]            count;
  } script_row_t;

  // Opening sequence from an empty list. Rows marked typed carry their
  // expected result; the others take it from the list model.
  script_row_t script [25] = '{
    '{OP_DELETE, 32'sd0,          1'b1, ST_MISSING, 7'd0},
    '{OP_INSERT, 32'sd0,          1'b1, ST_ADDED,   7'd1},
    '{OP_INSERT, 32'sd0,          1'b1, ST_DUP,     7'd1},
    '{OP_INSERT, VAL_MIN,         1'b1, ST_ADDED,   7'd2},
    '{OP_INSERT, VAL_MAX,         1'b1, ST_ADDED,   7'd3},
    '{OP_INSERT, -32'sd1,         1'b1, ST_ADDED,   7'd4},
    '{OP_INSERT, 32'sd1,          1'b1, ST_ADDED,   7'd5},
    '{OP_INSERT, VAL_MIN,         1'b1, ST_DUP,     7'd5},
    '{OP_INSERT, VAL_MAX,         1'b1, ST_DUP,     7'd5},
    '{OP_DELETE, 32'sd2,          1'b1, ST_MISSING, 7'd5},
    '{OP_DELETE, VAL_MIN,         1'b1, ST_DELETED, 7'd4},
    '{OP_DELETE, VAL_MAX,         1'b1, ST_DELETED, 7'd3},
    '{OP_DELETE, 32'sd0,          1'b1, ST_DELETED, 7'd2},
    '{OP_DELETE, 32'sd0,          1'b1, ST_MISSING, 7'd2},
    '{OP_INSERT, 32'sh5555_5555,  1'b0, ST_ADDED,   7'd0},
    '{OP_INSERT, 32'shaaaa_aaaa,  1'b0, ST_ADDED,   7'd0},
    '{OP_INSERT, 32'sh7fff_fffe,  1'b0, ST_ADDED,   7'd0},
    '{OP_INSERT, 32'sh8000_0001,  1'b0, ST_ADDED,   7'd0},
    '{OP_DELETE, 32'sh5555_5555,  1'b0, ST_ADDED,   7'd0},
    '{OP_DELETE, -32'sd1,         1'b0, ST_ADDED,   7'd0},
    '{OP_DELETE, 32'sd1,          1'b0, ST_ADDED,   7'd0},
    '{OP_DELETE, 32'shaaaa_aaaa,  1'b0, ST_ADDED,   7'd0},
    '{OP_DELETE, 32'sh7fff_fffe,  1'b0, ST_ADDED,   7'd0},
    '{OP_DELETE, 32'sh8000_0001,  1'b1, ST_DELETED, 7'd0},
    '{OP_DELETE, 32'sh8000_0001,  1'b1, ST_MISSING, 7'd0}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          in_op = 1'b0;
  logic signed [VALUE_WIDTH-1:0] in_value = '0;
  logic                          busy;
  logic                          out_valid;
  logic [STATUS_W-1:0]           out_status;
  logic [COUNT_W-1:0]            out_entry_count;

  // Model state: the set held in ascending order, and results still owed.
  logic signed [VALUE_WIDTH-1:0] members [$];
  list_result_t                  pending [$];

  bit steady = 1'b0;
  int errors = 0;
  int sent = 0;
  int peak_entries = 0;
  int status_tally [5] = '{0, 0, 0, 0, 0};
  int quiet_cycles = 0;

  sorted_set_list_engine_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Position of a value in the held set, or -1 when it is absent.
  function automatic int find_member(input logic signed [VALUE_WIDTH-1:0] v);
    foreach (members[i]) begin
      if (members[i] == v) return i;
    end
    return -1;
  endfunction

  // Applies one transaction to the sorted set and returns what the block
  // should report for it.
  function automatic list_result_t apply_op(input list_op_t op,
                                            input logic signed [VALUE_WIDTH-1:0] v);
    list_result_t r;
    int at;
    int pos;
    at = find_member(v);
    pos = 0;
    if (op == OP_INSERT) begin
      if (at >= 0) begin
        r.status = ST_DUP;
      end else if (members.size() == CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        while (pos < members.size() && members[pos] < v) pos++;
        members.insert(pos, v);
        r.status = ST_ADDED;
      end
    end else if (at < 0) begin
      r.status = ST_MISSING;
    end else begin
      members.delete(at);
      r.status = ST_DELETED;
    end
    r.entry_count = COUNT_W'(members.size());
    return r;
  endfunction

  // Key choice: held values, a narrow band that collides often, the
  // corners of the signed range, or any 32-bit pattern.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input bit from_set);
    int band;
    if (from_set && members.size() > 0) return members[$urandom_range(0, members.size() - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        band = $urandom_range(0, 80);
        return band - 40;
      end
      4: begin
        case ($urandom_range(0, 5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] fresh_value();
    logic signed [VALUE_WIDTH-1:0] v;
    do v = $urandom(); while (find_member(v) >= 0);
    return v;
  endfunction

  // Offers one transaction, holds it until accepted, records what is owed,
  // and then may leave the request line low for a while.
  task automatic issue(input list_op_t op, input logic signed [VALUE_WIDTH-1:0] v,
                       input bit typed, input list_result_t typed_res);
    list_result_t res;
    int gap;
    in_op    <= op;
    in_value <= v;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    res = apply_op(op, v);
    if (typed) res = typed_res;
    pending.push_back(res);
    sent++;
    status_tally[res.status]++;
    if (members.size() > peak_entries) peak_entries = members.size();
    if (!steady && $urandom_range(0, 99) < 33) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds off new transactions until every owed result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending.size() != 0);
    @(posedge clk);
  endtask

  // Result checker: every strobe must match the oldest owed result.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $display("%0t: result with none owed: status %0d count %0d",
                 $time, out_status, out_entry_count);
        errors++;
      end else begin
        want = pending.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_entry_count !== want.entry_count) begin
          $display("%0t: entry count expected %0d, got %0d",
                   $time, want.entry_count, out_entry_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results owed",
                 $time, quiet_cycles, pending.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    list_result_t typed_res;
    list_op_t     op;
    int           insert_pct;
    typed_res  = '0;
    insert_pct = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening sequence.
    foreach (script[i]) begin
      typed_res.status      = script[i].status;
      typed_res.entry_count = script[i].count;
      issue(script[i].op, script[i].value, script[i].typed, typed_res);
    end
    drain_results();

    // Fill the pool, then probe an exhausted pool with new and held values.
    while (members.size() < CAPACITY) issue(OP_INSERT, fresh_value(), 1'b0, typed_res);
    typed_res.status      = ST_FULL;
    typed_res.entry_count = COUNT_W'(CAPACITY);
    issue(OP_INSERT, fresh_value(), 1'b1, typed_res);
    typed_res.status = ST_DUP;
    issue(OP_INSERT, members[$urandom_range(0, CAPACITY - 1)], 1'b1, typed_res);
    typed_res.status = ST_DUP;
    issue(OP_INSERT, members[CAPACITY - 1], 1'b1, typed_res);
    typed_res.status      = ST_DELETED;
    typed_res.entry_count = COUNT_W'(CAPACITY - 1);
    issue(OP_DELETE, members[$urandom_range(0, CAPACITY - 1)], 1'b1, typed_res);
    issue(OP_INSERT, fresh_value(), 1'b0, typed_res);

    // Random traffic in phases that grow, churn and shrink the list.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 400 && n < 600);
      if (n % 100 == 0) begin
        case ((n / 100) % 3)
          0: insert_pct = 80;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
        if (n % 300 == 150 - 50) drain_results();
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
      if (op == OP_DELETE) begin
        issue(op, pick_value($urandom_range(0, 99) < 65), 1'b0, typed_res);
      end else begin
        issue(op, pick_value($urandom_range(0, 99) < 15), 1'b0, typed_res);
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d transactions: %0d added, %0d duplicate, %0d deleted,",
             sent, status_tally[ST_ADDED], status_tally[ST_DUP], status_tally[ST_DELETED]);
    $display("%0d not found, %0d refused on a full pool; list peaked at %0d entries.",
             status_tally[ST_MISSING], status_tally[ST_FULL], peak_entries);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
